// ===== sv/scfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scfp_pkg - shared types and constants for the servo command frame parser
// Character codes, parse phases, status codes, register indexes and helpers.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int NUM_PWM    = 6;
  localparam int PWM_W      = 12;
  localparam int DUR_W      = 14;
  localparam int ID_W       = 10;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int SERVO_COUNT_DEF = 6;

  localparam logic [DUR_W-1:0] PWM_MIN   = DUR_W'(500);
  localparam logic [DUR_W-1:0] PWM_MAX   = DUR_W'(2500);
  localparam logic [DUR_W-1:0] DUR_FLOOR = DUR_W'(20);

  localparam logic [CNT_W-1:0] ID_DIGITS    = CNT_W'(3);
  localparam logic [CNT_W-1:0] FIELD_DIGITS = CNT_W'(4);

  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_P      = 8'h50;  // 'P'
  localparam logic [7:0] CH_T      = 8'h54;  // 'T'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_ONLY_TASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PWM0  = CFG_IDX_W'(1);

  typedef enum logic [6:0] {
    PH_SCAN = 7'b0000001,
    PH_ID   = 7'b0000010,
    PH_P    = 7'b0000100,
    PH_PWM  = 7'b0001000,
    PH_T    = 7'b0010000,
    PH_DUR  = 7'b0100000,
    PH_END  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    ST_FORWARDED = 2'd0,
    ST_INVALID   = 2'd1,
    ST_IGNORED   = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_PWM-1:0][PWM_W-1:0] pwm;
    logic [DUR_W-1:0]              dur;
    status_t                       status;
  } result_t;

  function automatic logic [PWM_W-1:0] clamp_pwm(input logic [DUR_W-1:0] v);
    logic [DUR_W-1:0] c;
    begin
      if (v < PWM_MIN) begin
        c = PWM_MIN;
      end else if (v > PWM_MAX) begin
        c = PWM_MAX;
      end else begin
        c = v;
      end
      return c[PWM_W-1:0];
    end
  endfunction

  function automatic logic [PWM_W-1:0] reset_pwm(input int k);
    logic [PWM_W-1:0] v;
    begin
      case (k)
        1:       v = PWM_W'(1350);
        2:       v = PWM_W'(2300);
        default: v = PWM_W'(1500);
      endcase
      return v;
    end
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== sv/servo_command_frame_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_frame_parser_top - servo command frame parser
// Parses '{ #iiiPppppTdddd! ... }' frames byte by byte, holds six servo PWMs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one ASCII byte per transaction plus the task mode flag, which is
//           only looked at on the closing '}'.
//   out_* : one status transaction per '}' that closes a frame: all six held
//           PWMs, the move duration (0 unless forwarded) and the status.
//   cfg_* : register writes (index 0 gating flag, 1..6 default PWMs); a PWM
//           write is clamped and also loads the held value. Always ready.
// Throughput is one byte per cycle while in_ready is high: each byte is one
// update of the parse registers. The result of a closing '}' is registered in
// an output register backed by one skid entry, so bytes keep flowing while a
// result waits; in_ready drops only once the skid entry is occupied, i.e.
// when a second result is pending behind a stalled receiver.
// Reset (synchronous, rst_n low) leaves the parser outside a frame, clears
// both result stages and loads the reset default PWMs and gating flag.
// ----------------------------------------------------------------------------
module servo_command_frame_parser_top #(
  parameter int SERVO_COUNT = scfp_pkg::SERVO_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_data_byte,
  input  wire logic                             in_task_active,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [scfp_pkg::PWM_W-1:0]            out_pwm_0,
  output logic [scfp_pkg::PWM_W-1:0]            out_pwm_1,
  output logic [scfp_pkg::PWM_W-1:0]            out_pwm_2,
  output logic [scfp_pkg::PWM_W-1:0]            out_pwm_3,
  output logic [scfp_pkg::PWM_W-1:0]            out_pwm_4,
  output logic [scfp_pkg::PWM_W-1:0]            out_pwm_5,
  output logic [scfp_pkg::DUR_W-1:0]            out_move_duration,
  output logic [1:0]                            out_frame_status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scfp_pkg::PWM_W-1:0]       cfg_data
);

  localparam int PW = scfp_pkg::PWM_W;
  localparam int DW = scfp_pkg::DUR_W;
  localparam int IW = scfp_pkg::ID_W;
  localparam int CW = scfp_pkg::CNT_W;

  // parse state
  logic                      in_frame_r, in_frame_nxt;
  scfp_pkg::phase_t          phase_r, phase_nxt;
  logic [CW-1:0]             digit_cnt_r, digit_cnt_nxt;
  logic [IW-1:0]             servo_num_r, servo_num_nxt;
  logic [DW-1:0]             field_r, field_nxt;
  logic [PW-1:0]             staged_pwm_r [SERVO_COUNT];
  logic [PW-1:0]             staged_pwm_nxt [SERVO_COUNT];
  logic [SERVO_COUNT-1:0]    staged_mask_r, staged_mask_nxt;
  logic [DW-1:0]             longest_r, longest_nxt;
  logic                      any_servo_r, any_servo_nxt;
  logic                      frame_bad_r, frame_bad_nxt;
  logic [PW-1:0]             held_pwm_r [scfp_pkg::NUM_PWM];
  logic [PW-1:0]             held_pwm_nxt [scfp_pkg::NUM_PWM];
  logic                      fwd_only_r, fwd_only_nxt;

  // result stages
  logic                      out_valid_r, skid_valid_r;
  scfp_pkg::result_t         out_r, skid_r;
  scfp_pkg::result_t         res;
  logic                      res_push;

  logic                      in_fire, cfg_fire, pop;
  logic [3:0]                digit;
  logic                      servo_ok;
  logic [CW-1:0]             cnt_inc;
  logic [IW+3:0]             id_acc;
  logic [DW+3:0]             field_acc;

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign pop       = out_valid_r && out_ready;

  assign digit     = 4'(in_data_byte - scfp_pkg::CH_ZERO);
  assign servo_ok  = servo_num_r < IW'(SERVO_COUNT);
  assign cnt_inc   = digit_cnt_r + CW'(1);
  assign id_acc    = (IW+4)'(servo_num_r) * (IW+4)'(10) + (IW+4)'(digit);
  assign field_acc = (DW+4)'(field_r) * (DW+4)'(10) + (DW+4)'(digit);

  always_comb begin
    logic clear;
    clear           = 1'b0;
    in_frame_nxt    = in_frame_r;
    phase_nxt       = phase_r;
    digit_cnt_nxt   = digit_cnt_r;
    servo_num_nxt   = servo_num_r;
    field_nxt       = field_r;
    staged_pwm_nxt  = staged_pwm_r;
    staged_mask_nxt = staged_mask_r;
    longest_nxt     = longest_r;
    any_servo_nxt   = any_servo_r;
    frame_bad_nxt   = frame_bad_r;
    held_pwm_nxt    = held_pwm_r;
    fwd_only_nxt    = fwd_only_r;
    res_push        = 1'b0;
    res.dur         = '0;
    res.status      = scfp_pkg::ST_FORWARDED;

    if (in_fire) begin
      if (in_data_byte == scfp_pkg::CH_LBRACE) begin
        in_frame_nxt = 1'b1;
        clear        = 1'b1;
      end else if (in_frame_r && in_data_byte == scfp_pkg::CH_RBRACE) begin
        in_frame_nxt = 1'b0;
        clear        = 1'b1;
        res_push     = 1'b1;
        if (frame_bad_r || phase_r != scfp_pkg::PH_SCAN || !any_servo_r) begin
          res.status = scfp_pkg::ST_INVALID;
        end else if (fwd_only_r && !in_task_active) begin
          res.status = scfp_pkg::ST_IGNORED;
        end else begin
          for (int k = 0; k < SERVO_COUNT; k++) begin
            if (staged_mask_r[k]) begin
              held_pwm_nxt[k] = staged_pwm_r[k];
            end
          end
          res.dur = (longest_r < scfp_pkg::DUR_FLOOR) ? scfp_pkg::DUR_FLOOR : longest_r;
        end
      end else if (in_frame_r && !frame_bad_r) begin
        case (phase_r)
          scfp_pkg::PH_SCAN: begin
            if (in_data_byte == scfp_pkg::CH_HASH) begin
              phase_nxt     = scfp_pkg::PH_ID;
              digit_cnt_nxt = '0;
              servo_num_nxt = '0;
            end
          end
          scfp_pkg::PH_ID: begin
            if (!scfp_pkg::is_digit(in_data_byte)) begin
              frame_bad_nxt = 1'b1;
            end else begin
              servo_num_nxt = id_acc[IW-1:0];
              digit_cnt_nxt = cnt_inc;
              if (cnt_inc >= scfp_pkg::ID_DIGITS) begin
                phase_nxt     = scfp_pkg::PH_P;
                digit_cnt_nxt = '0;
              end
            end
          end
          scfp_pkg::PH_P: begin
            if (in_data_byte == scfp_pkg::CH_P) begin
              phase_nxt     = scfp_pkg::PH_PWM;
              digit_cnt_nxt = '0;
              field_nxt     = '0;
            end else begin
              frame_bad_nxt = 1'b1;
            end
          end
          scfp_pkg::PH_PWM, scfp_pkg::PH_DUR: begin
            if (!scfp_pkg::is_digit(in_data_byte)) begin
              frame_bad_nxt = 1'b1;
            end else begin
              field_nxt     = field_acc[DW-1:0];
              digit_cnt_nxt = cnt_inc;
              if (cnt_inc >= scfp_pkg::FIELD_DIGITS) begin
                phase_nxt     = (phase_r == scfp_pkg::PH_PWM) ? scfp_pkg::PH_T
                                                              : scfp_pkg::PH_END;
                digit_cnt_nxt = '0;
              end
            end
          end
          scfp_pkg::PH_T: begin
            if (in_data_byte == scfp_pkg::CH_T) begin
              for (int k = 0; k < SERVO_COUNT; k++) begin
                if (servo_num_r == IW'(k)) begin
                  staged_pwm_nxt[k]  = scfp_pkg::clamp_pwm(field_r);
                  staged_mask_nxt[k] = 1'b1;
                end
              end
              phase_nxt     = scfp_pkg::PH_DUR;
              digit_cnt_nxt = '0;
              field_nxt     = '0;
            end else begin
              frame_bad_nxt = 1'b1;
            end
          end
          scfp_pkg::PH_END: begin
            if (in_data_byte == scfp_pkg::CH_BANG) begin
              if (servo_ok) begin
                if (field_r > longest_r) begin
                  longest_nxt = field_r;
                end
                any_servo_nxt = 1'b1;
              end
              phase_nxt = scfp_pkg::PH_SCAN;
            end else begin
              frame_bad_nxt = 1'b1;
            end
          end
          default: frame_bad_nxt = 1'b1;
        endcase
      end
    end

    if (clear) begin
      phase_nxt       = scfp_pkg::PH_SCAN;
      digit_cnt_nxt   = '0;
      servo_num_nxt   = '0;
      field_nxt       = '0;
      staged_mask_nxt = '0;  // staged PWMs are only read under the mask
      longest_nxt     = '0;
      any_servo_nxt   = 1'b0;
      frame_bad_nxt   = 1'b0;
    end

    // result carries the held values after this frame's merge
    for (int k = 0; k < scfp_pkg::NUM_PWM; k++) begin
      res.pwm[k] = held_pwm_nxt[k];
    end

    // the user must issue config writes only while idle; the block does not enforce it
    if (cfg_fire) begin
      if (cfg_index == scfp_pkg::CFG_FWD_ONLY_TASK) begin
        fwd_only_nxt = cfg_data[0];
      end
      for (int k = 0; k < scfp_pkg::NUM_PWM; k++) begin
        if (cfg_index == scfp_pkg::CFG_DEFAULT_PWM0 + scfp_pkg::CFG_IDX_W'(k)) begin
          held_pwm_nxt[k] = scfp_pkg::clamp_pwm(DW'(cfg_data));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      phase_r       <= scfp_pkg::PH_SCAN;
      digit_cnt_r   <= '0;
      servo_num_r   <= '0;
      field_r       <= '0;
      staged_mask_r <= '0;
      longest_r     <= '0;
      any_servo_r   <= 1'b0;
      frame_bad_r   <= 1'b0;
      fwd_only_r    <= 1'b1;
      for (int k = 0; k < scfp_pkg::NUM_PWM; k++) begin
        held_pwm_r[k] <= scfp_pkg::reset_pwm(k);
      end
    end else begin
      in_frame_r    <= in_frame_nxt;
      phase_r       <= phase_nxt;
      digit_cnt_r   <= digit_cnt_nxt;
      servo_num_r   <= servo_num_nxt;
      field_r       <= field_nxt;
      staged_mask_r <= staged_mask_nxt;
      longest_r     <= longest_nxt;
      any_servo_r   <= any_servo_nxt;
      frame_bad_r   <= frame_bad_nxt;
      fwd_only_r    <= fwd_only_nxt;
      held_pwm_r    <= held_pwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    staged_pwm_r <= staged_pwm_nxt;
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_0         = out_r.pwm[0];
  assign out_pwm_1         = out_r.pwm[1];
  assign out_pwm_2         = out_r.pwm[2];
  assign out_pwm_3         = out_r.pwm[3];
  assign out_pwm_4         = out_r.pwm[4];
  assign out_pwm_5         = out_r.pwm[5];
  assign out_move_duration = out_r.dur;
  assign out_frame_status  = out_r.status;

  // ---------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_fwd_dur_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == scfp_pkg::ST_FORWARDED) |->
      (out_r.dur >= scfp_pkg::DUR_FLOOR))
    else $error("forwarded frame with duration below floor");

  a_nofwd_dur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != scfp_pkg::ST_FORWARDED) |-> (out_r.dur == '0))
    else $error("non-forwarded frame with nonzero duration");

  a_result_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (in_frame_r && in_data_byte == scfp_pkg::CH_RBRACE && !in_frame_nxt))
    else $error("result raised without a closing brace inside a frame");

  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.pwm[0] >= 12'd500 && out_r.pwm[0] <= 12'd2500 &&
                     out_r.pwm[5] >= 12'd500 && out_r.pwm[5] <= 12'd2500))
    else $error("held pwm out of range");

endmodule

`default_nettype wire

// ===== sim/servo_command_frame_parser_checker.sv =====
// ----------------------------------------------------------------------------
// servo_command_frame_parser_checker - scoreboard for the frame parser
// Watches the byte, result and register channels, runs its own model of the
// parser on every accepted byte and register write, and compares each result
// transaction field by field with the oldest predicted frame report.
// ----------------------------------------------------------------------------
module servo_command_frame_parser_checker
  import scfp_pkg::*;
#(
  parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_task_active,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [PWM_W-1:0]     out_pwm_0,
  input  wire logic [PWM_W-1:0]     out_pwm_1,
  input  wire logic [PWM_W-1:0]     out_pwm_2,
  input  wire logic [PWM_W-1:0]     out_pwm_3,
  input  wire logic [PWM_W-1:0]     out_pwm_4,
  input  wire logic [PWM_W-1:0]     out_pwm_5,
  input  wire logic [DUR_W-1:0]     out_move_duration,
  input  wire logic [1:0]           out_frame_status,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PWM_W-1:0]     cfg_data,
  output int                        mismatch_count,
  output int                        reports_due
);

  localparam logic [NUM_PWM-1:0][PWM_W-1:0] POWER_ON_PWM = {
    PWM_W'(1500), PWM_W'(1500), PWM_W'(1500), PWM_W'(2300), PWM_W'(1350), PWM_W'(1500)
  };

  result_t due_reports[$];
  int      errors = 0;

  // model state
  logic                          gate_outside_task;
  logic [NUM_PWM-1:0][PWM_W-1:0] held;
  logic                          framing;
  phase_t                        phase;
  logic [CNT_W-1:0]              ndigits;
  logic [ID_W-1:0]               group_id;
  logic [DUR_W-1:0]              acc;
  logic [NUM_PWM-1:0][PWM_W-1:0] staged;
  logic [NUM_PWM-1:0]            staged_mask;
  logic [DUR_W-1:0]              longest;
  logic                          seen_servo;
  logic                          bad;

  assign mismatch_count = errors;

  task automatic report_mismatch(input string msg);
    $display("[%0t] frame checker: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [PWM_W-1:0] pulse_limit(input logic [DUR_W-1:0] v);
    if (v < PWM_MIN) return PWM_MIN[PWM_W-1:0];
    if (v > PWM_MAX) return PWM_MAX[PWM_W-1:0];
    return v[PWM_W-1:0];
  endfunction

  function automatic logic is_decimal(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic id_known();
    return int'(group_id) < SERVO_COUNT && int'(group_id) < NUM_PWM;
  endfunction

  task automatic clear_frame_state();
    phase       = PH_SCAN;
    ndigits     = '0;
    group_id    = '0;
    acc         = '0;
    staged      = '0;
    staged_mask = '0;
    longest     = '0;
    seen_servo  = 1'b0;
    bad         = 1'b0;
  endtask

  task automatic count_digit(input logic [CNT_W-1:0] want, input phase_t next);
    ndigits = ndigits + 1'b1;
    if (ndigits >= want) begin
      phase   = next;
      ndigits = '0;
    end
  endtask

  task automatic parse_group_byte(input logic [7:0] b);
    case (phase)
      PH_SCAN: begin
        if (b == CH_HASH) begin
          phase    = PH_ID;
          ndigits  = '0;
          group_id = '0;
        end
      end
      PH_ID: begin
        if (!is_decimal(b)) begin
          bad = 1'b1;
        end else begin
          group_id = ID_W'(group_id * 10 + (b - CH_ZERO));
          count_digit(ID_DIGITS, PH_P);
        end
      end
      PH_P: begin
        if (b == CH_P) begin
          phase   = PH_PWM;
          ndigits = '0;
          acc     = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_PWM, PH_DUR: begin
        if (!is_decimal(b)) begin
          bad = 1'b1;
        end else begin
          acc = DUR_W'(acc * 10 + (b - CH_ZERO));
          count_digit(FIELD_DIGITS, (phase == PH_PWM) ? PH_T : PH_END);
        end
      end
      PH_T: begin
        if (b == CH_T) begin
          if (id_known()) begin
            staged[group_id[2:0]]      = pulse_limit(acc);
            staged_mask[group_id[2:0]] = 1'b1;
          end
          phase   = PH_DUR;
          ndigits = '0;
          acc     = '0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_END: begin
        if (b == CH_BANG) begin
          if (id_known()) begin
            if (acc > longest) longest = acc;
            seen_servo = 1'b1;
          end
          phase = PH_SCAN;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
  endtask

  task automatic close_frame(input logic task_flag);
    result_t r;
    int      k;
    r.dur   = '0;
    framing = 1'b0;
    if (bad || phase != PH_SCAN || !seen_servo) begin
      r.status = ST_INVALID;
    end else if (gate_outside_task && !task_flag) begin
      r.status = ST_IGNORED;
    end else begin
      r.status = ST_FORWARDED;
      for (k = 0; k < NUM_PWM; k++) begin
        if (staged_mask[k]) held[k] = staged[k];
      end
      r.dur = (longest < DUR_FLOOR) ? DUR_FLOOR : longest;
    end
    r.pwm = held;
    due_reports.insert(due_reports.size(), r);
    clear_frame_state();
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic task_flag);
    if (b == CH_LBRACE) begin
      // an opening brace always restarts, in or out of a frame
      framing = 1'b1;
      clear_frame_state();
    end else if (framing) begin
      if (b == CH_RBRACE) begin
        close_frame(task_flag);
      end else if (!bad) begin
        parse_group_byte(b);
      end
    end
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [PWM_W-1:0] data);
    if (idx == CFG_FWD_ONLY_TASK) begin
      gate_outside_task = data[0];
    end else if (idx >= CFG_DEFAULT_PWM0 &&
                 int'(idx) < int'(CFG_DEFAULT_PWM0) + NUM_PWM) begin
      held[idx - CFG_DEFAULT_PWM0] = pulse_limit(DUR_W'(data));
    end
  endtask

  task automatic check_report();
    result_t                       want;
    logic [NUM_PWM-1:0][PWM_W-1:0] got_pwm;
    int                            k;
    if (due_reports.size() == 0) begin
      report_mismatch($sformatf("result transaction with no frame pending, status %0d",
                                out_frame_status));
      return;
    end
    want    = due_reports.pop_front();
    got_pwm = {out_pwm_5, out_pwm_4, out_pwm_3, out_pwm_2, out_pwm_1, out_pwm_0};
    for (k = 0; k < NUM_PWM; k++) begin
      if (got_pwm[k] !== want.pwm[k])
        report_mismatch($sformatf("pwm_%0d got %0d expected %0d", k, got_pwm[k],
                                  want.pwm[k]));
    end
    if (out_move_duration !== want.dur)
      report_mismatch($sformatf("move_duration got %0d expected %0d", out_move_duration,
                                want.dur));
    if (out_frame_status !== want.status)
      report_mismatch($sformatf("frame_status got %0d expected %0d", out_frame_status,
                                int'(want.status)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gate_outside_task = 1'b1;
      held              = POWER_ON_PWM;
      framing           = 1'b0;
      clear_frame_state();
      due_reports.delete();
    end else begin
      // results leave only after their '}' was accepted, so the pop comes first
      if (out_valid && out_ready) check_report();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) advance_parser(in_data_byte, in_task_active);
    end
    reports_due <= due_reports.size();
  end

endmodule

// ===== sim/servo_command_frame_parser_top_test.sv =====
// ----------------------------------------------------------------------------
// servo_command_frame_parser_top_test - regression for the frame parser
// Drives directed and random byte streams (clean frames, corrupted frames,
// noise) under random idling on both channels and a long result stall, with
// register settings changed between phases. The checker does the scoring.
// ----------------------------------------------------------------------------
module servo_command_frame_parser_top_test;
  import scfp_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 64;
  localparam int PHASE_FRAMES = 2;
  localparam int RUN_LIMIT    = 4000000;

  localparam logic [CFG_IDX_W-1:0] CFG_BEYOND = CFG_IDX_W'(NUM_PWM + 1);

  // stray characters used in directed frames
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_LOW_Y = 8'h79;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_data_byte;
  logic                 in_task_active;
  logic                 out_valid;
  logic                 out_ready;
  logic [PWM_W-1:0]     out_pwm_0;
  logic [PWM_W-1:0]     out_pwm_1;
  logic [PWM_W-1:0]     out_pwm_2;
  logic [PWM_W-1:0]     out_pwm_3;
  logic [PWM_W-1:0]     out_pwm_4;
  logic [PWM_W-1:0]     out_pwm_5;
  logic [DUR_W-1:0]     out_move_duration;
  logic [1:0]           out_frame_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PWM_W-1:0]     cfg_data;
  int                   mismatch_count;
  int                   reports_due;

  bit       calm     = 1'b0;
  bit       hold_req = 1'b0;
  bit [8:0] byte_stream[$];  // {task flag, byte}

  servo_command_frame_parser_top DUT (.*);

  servo_command_frame_parser_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("servo_command_frame_parser_top regression: fail");
    $finish;
  end

  // result side: random ready gaps, plus one long stall on request
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  function automatic void put(input logic [7:0] b, input logic t);
    byte_stream.insert(byte_stream.size(), {t, b});
  endfunction

  function automatic void put_any(input logic [7:0] b);
    put(b, 1'($urandom_range(0, 1)));
  endfunction

  function automatic void put_num(input int value, input int digits);
    int div;
    div = 1;
    repeat (digits - 1) div = div * 10;
    repeat (digits) begin
      put_any(8'(int'(CH_ZERO) + (value / div) % 10));
      div = div / 10;
    end
  endfunction

  function automatic void put_group(input int id, input int pwm, input int dur);
    put_any(CH_HASH);
    put_num(id, 3);
    put_any(CH_P);
    put_num(pwm, 4);
    put_any(CH_T);
    put_num(dur, 4);
    put_any(CH_BANG);
  endfunction

  // filler between groups: anything that neither opens a group nor a frame
  function automatic void put_junk();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_HASH || b == CH_LBRACE || b == CH_RBRACE) b = CH_BANG;
    put_any(b);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_task_active <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_stream();
    bit [8:0] e;
    while (byte_stream.size() != 0) begin
      e = byte_stream.pop_front();
      send_byte(e[7:0], e[8]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PWM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop offering bytes and wait until every frame report has been taken
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_settings();
    int k;
    int v;
    write_reg(CFG_FWD_ONLY_TASK, PWM_W'($urandom_range(0, 4095)));
    for (k = 0; k < NUM_PWM; k++) begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = 4095;
        2:       v = $urandom_range(0, 4095);
        default: v = $urandom_range(500, 2500);
      endcase
      write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + k), PWM_W'(v));
    end
    write_reg(CFG_BEYOND, PWM_W'($urandom_range(0, 4095)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase();
    int sent;
    int built;
    int kind;
    int groups;
    int start;
    int pos;
    int g;
    random_settings();
    sent  = 0;
    built = 0;
    while (sent < PHASE_BYTES || built < PHASE_FRAMES) begin
      calm = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 10)) put_any(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) put_junk();
        start = byte_stream.size();
        put_any(CH_LBRACE);
        groups = $urandom_range(0, 4);
        for (g = 0; g < groups; g++) begin
          repeat ($urandom_range(0, 2)) put_junk();
          if ($urandom_range(0, 19) == 0) put_any(CH_LBRACE);
          put_group(($urandom_range(0, 6) != 0) ? $urandom_range(0, 5) : $urandom_range(6, 999),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999)
                                                : $urandom_range(450, 2550),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                : $urandom_range(0, 9999));
        end
        // broken frames: one byte overwritten, or the tail cut off
        if (kind < 32 && byte_stream.size() > start + 1) begin
          pos = $urandom_range(start + 1, byte_stream.size() - 1);
          if ($urandom_range(0, 1) != 0) begin
            byte_stream[pos][7:0] = 8'($urandom_range(0, 255));
          end else begin
            while (byte_stream.size() > pos + 1) void'(byte_stream.pop_back());
          end
        end
        put(CH_RBRACE, $urandom_range(0, 3) != 0);
        built++;
      end
      sent += byte_stream.size();
      send_stream();
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin : stimulus
    int i;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_task_active = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, power-on settings: bytes outside a frame are dropped
    put_any(CH_RBRACE);
    put_any(8'h00);
    put_any(8'hFF);
    put_any(CH_HASH);
    // lowest and highest fields: pwm clamped up and down, low duration floored
    put_any(CH_LBRACE); put_group(0, 0, 0); put(CH_RBRACE, 1'b1);
    put_any(CH_LBRACE); put_group(5, 9999, 9999); put(CH_RBRACE, 1'b1);
    // valid frame outside task mode is gated
    put_any(CH_LBRACE); put_group(2, 1200, 300); put(CH_RBRACE, 1'b0);
    // no servo at all, and only unknown ids
    put_any(CH_LBRACE); put(CH_RBRACE, 1'b1);
    put_any(CH_LBRACE); put_group(6, 1000, 100); put_group(999, 1000, 100);
    put(CH_RBRACE, 1'b1);
    // letter in the id, even with a clean group after it
    put_any(CH_LBRACE); put_any(CH_HASH); put_any(CH_ZERO); put_any(CH_A);
    put_group(1, 1000, 100); put(CH_RBRACE, 1'b1);
    // missing P, missing T, missing closing bang
    put_any(CH_LBRACE); put_any(CH_HASH); put_num(1, 3); put_any(CH_Q); put_num(1000, 4);
    put_any(CH_T); put_num(100, 4); put_any(CH_BANG); put(CH_RBRACE, 1'b1);
    put_any(CH_LBRACE); put_any(CH_HASH); put_num(1, 3); put_any(CH_P); put_num(1000, 4);
    put_any(CH_X); put_num(100, 4); put_any(CH_BANG); put(CH_RBRACE, 1'b1);
    put_any(CH_LBRACE); put_any(CH_HASH); put_num(1, 3); put_any(CH_P); put_num(1000, 4);
    put_any(CH_T); put_num(100, 4); put_any(CH_QMARK); put(CH_RBRACE, 1'b1);
    // closing brace in the middle of a group
    put_any(CH_LBRACE); put_any(CH_HASH); put_num(3, 3); put_any(CH_P); put_num(12, 2);
    put(CH_RBRACE, 1'b1);
    // malformed and outside task mode: invalid wins over gating
    put_any(CH_LBRACE); put_any(CH_HASH); put_num(1, 3); put_any(CH_P); put_num(1000, 4);
    put_any(CH_T); put_num(10, 3); put_any(CH_X); put(CH_RBRACE, 1'b0);
    // same id twice, last one stands
    put_any(CH_LBRACE); put_group(1, 600, 10); put_group(1, 700, 30); put(CH_RBRACE, 1'b1);
    // reopening brace drops the first group
    put_any(CH_LBRACE); put_group(2, 800, 50); put_any(CH_LBRACE); put_group(3, 900, 40);
    put(CH_RBRACE, 1'b1);
    // filler between groups
    put_any(CH_LBRACE); put_any(CH_LOW_X); put_any(CH_LOW_Y); put_group(4, 1234, 100);
    put_any(CH_LOW_X); put_any(CH_BANG); put(CH_RBRACE, 1'b1);
    // all six servos
    put_any(CH_LBRACE);
    for (i = 0; i < NUM_PWM; i++) put_group(i, 501 + i * 399, 1 + i * 3);
    put(CH_RBRACE, 1'b1);
    send_stream();
    settle();

    // every register, with out-of-range values and the unused index
    write_reg(CFG_FWD_ONLY_TASK, PWM_W'(1));
    write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + 0), PWM_W'(0));
    write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + 1), PWM_W'(4095));
    write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + 2), PWM_W'(499));
    write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + 3), PWM_W'(2501));
    write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + 4), PWM_W'(500));
    write_reg(CFG_IDX_W'(int'(CFG_DEFAULT_PWM0) + 5), PWM_W'(2500));
    write_reg(CFG_BEYOND, PWM_W'(1234));
    cfg_valid <= 1'b0;
    put_any(CH_LBRACE); put(CH_RBRACE, 1'b1);
    put_any(CH_LBRACE); put_group(3, 400, 0); put(CH_RBRACE, 1'b1);
    send_stream();
    settle();

    // gating off: forwarded even outside task mode
    write_reg(CFG_FWD_ONLY_TASK, PWM_W'(0));
    cfg_valid <= 1'b0;
    put_any(CH_LBRACE); put_group(4, 2600, 5000); put(CH_RBRACE, 1'b0);
    send_stream();
    settle();

    repeat (4) run_random_phase();

    // long result stall while frames keep coming, so the input backs up
    random_settings();
    hold_req = 1'b1;
    calm     = 1'b1;
    for (i = 0; i < 24; i++) begin
      put_any(CH_LBRACE);
      if (i % 2 != 0) put_group($urandom_range(0, 5), $urandom_range(0, 9999),
                                $urandom_range(0, 9999));
      put_any(CH_RBRACE);
      send_stream();
    end
    calm = 1'b0;
    settle();

    if (mismatch_count == 0 && reports_due == 0) begin
      $display("servo_command_frame_parser_top regression: pass");
    end else begin
      $display("servo_command_frame_parser_top regression: fail");
    end
    $finish;
  end

endmodule
